[hdl/cbs_pkg.sv]
// ============================================================================
// cbs_pkg - shared definitions for the cardinal B-spline evaluator
// Widths of the fixed-point formats, the lane word and the control word that
// travels down the pipeline beside the basis values.
// ============================================================================
`default_nettype none

package cbs_pkg;

  // Fixed-point formats of the ports.
  localparam int FRAC_BITS      = 16;
  localparam int POS_W          = 20;
  localparam int INT_W          = POS_W - FRAC_BITS;
  localparam int DEG_W          = 3;
  localparam int RES_W          = 18;
  localparam int MAX_DEGREE_DEF = 5;

  // Internal working format: basis values carry 60 fractional bits.
  localparam int WORK_BITS = 60;
  localparam int LANE_W    = WORK_BITS + 1;
  localparam int SUM_W     = 64;
  localparam int SPLIT     = 30;
  localparam int ROUND_SH  = WORK_BITS - FRAC_BITS;

  // Lane index, wide enough for the largest supported degree.
  localparam int IDX_W = 3;

  typedef logic [LANE_W-1:0] cbs_lane_t;

  // Control word that travels with each word through the pipeline.
  typedef struct packed {
    logic             mode;
    logic [DEG_W-1:0] target;
    logic [IDX_W-1:0] idx;
    logic [FRAC_BITS-1:0] frac;
    logic             in_sup;
    logic             status;
  } cbs_ctrl_t;

endpackage

`default_nettype wire

[hdl/cardinal_bspline_evaluator.sv]
// ============================================================================
// cardinal_bspline_evaluator - cardinal B-spline value and first derivative
// Evaluates B(n,x) for degree 0 to MAX_DEGREE, or its derivative
// B(n-1,x) - B(n-1,x-1), at a signed fixed-point position, one word a cycle while busy is low.
// ============================================================================
//
//   channel  signals                                     handshake
//   -------  ------------------------------------------  ---------------------
//   input    in_mode, in_degree, in_x_position           start high, busy low
//   result   out_result_value, out_status                out_valid, one cycle
//
// A new word is taken in every cycle that start is high and busy is low. Each word
// passes through the input stage, one recurrence step for each degree, the select
// stage and the output stage; the divides by three and five in the odd degree steps
// make those steps deeper than the others.
// busy is high during reset and for the first cycle after it, low otherwise.
// Results cannot be held off: the pipeline never stalls.

`default_nettype none

module cardinal_bspline_evaluator
  import cbs_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_mode,
  input  logic [DEG_W-1:0]        in_degree,
  input  logic signed [POS_W-1:0] in_x_position,
  output logic                    out_valid,
  output logic signed [RES_W-1:0] out_result_value,
  output logic                    out_status
);

  localparam int LANES = MAX_DEGREE + 1;
  localparam int LW    = $clog2(LANES);
  localparam int RND_W = LANE_W + 1;
  localparam logic [DEG_W-1:0] MAX_DEG_C = DEG_W'(MAX_DEGREE);
  localparam logic [RND_W-1:0] RND_HALF  = RND_W'(1) << (ROUND_SH - 1);

  // Busy flag: held high through reset so that no word is lost.
  logic busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Input stage: decode the position and the target degree.
  logic [DEG_W-1:0] deg_sat;
  logic [INT_W-1:0] idx_full;
  logic             der0;
  logic             sup;
  cbs_ctrl_t        ctrl0_nxt;
  logic             valid0_r;
  cbs_ctrl_t        ctrl0_r;
  cbs_lane_t        lane0_r [LANES];

  always_comb begin
    deg_sat  = (in_degree > MAX_DEG_C) ? MAX_DEG_C : in_degree;
    idx_full = in_x_position[POS_W-1:FRAC_BITS];
    der0     = in_mode && (deg_sat == '0);
    sup      = !in_x_position[POS_W-1] && (idx_full <= INT_W'(deg_sat));
    ctrl0_nxt.mode   = in_mode;
    ctrl0_nxt.idx    = idx_full[IDX_W-1:0];
    ctrl0_nxt.frac   = in_x_position[FRAC_BITS-1:0];
    ctrl0_nxt.in_sup = sup && !der0;
    ctrl0_nxt.status = der0;
    if (!in_mode) begin
      ctrl0_nxt.target = deg_sat;
    end else if (der0) begin
      ctrl0_nxt.target = '0;
    end else begin
      ctrl0_nxt.target = deg_sat - DEG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else begin
      valid0_r <= start && !busy_r;
    end
    ctrl0_r <= ctrl0_nxt;
    for (int r = 0; r < LANES; r++) begin
      lane0_r[r] <= (r == 0) ? (LANE_W'(1) << WORK_BITS) : '0;
    end
  end

  // Recurrence: one step for each degree.
  logic      lv_valid [MAX_DEGREE+1];
  cbs_ctrl_t lv_ctrl  [MAX_DEGREE+1];
  cbs_lane_t lv_lane  [MAX_DEGREE+1][LANES];

  assign lv_valid[0] = valid0_r;
  assign lv_ctrl[0]  = ctrl0_r;
  assign lv_lane[0]  = lane0_r;

  for (genvar g = 1; g <= MAX_DEGREE; g++) begin : g_level
    cbs_level #(
      .LEVEL (g),
      .LANES (LANES)
    ) u_level (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lv_valid[g-1]),
      .in_ctrl   (lv_ctrl[g-1]),
      .in_lane   (lv_lane[g-1]),
      .out_valid (lv_valid[g]),
      .out_ctrl  (lv_ctrl[g]),
      .out_lane  (lv_lane[g])
    );
  end

  // Select stage: pick the basis value, or the difference for a derivative.
  cbs_ctrl_t        fin_ctrl;
  logic [LW-1:0]    sel;
  logic [LW-1:0]    sel_m1;
  cbs_lane_t        cur;
  cbs_lane_t        prv;
  cbs_lane_t        left;
  cbs_lane_t        right;
  cbs_lane_t        mag_nxt;
  logic             neg_nxt;
  logic             valid7_r;
  logic             status7_r;
  logic             neg7_r;
  cbs_lane_t        mag7_r;

  assign fin_ctrl = lv_ctrl[MAX_DEGREE];
  assign sel      = fin_ctrl.idx[LW-1:0];
  assign sel_m1   = sel - LW'(1);

  always_comb begin
    cur   = lv_lane[MAX_DEGREE][sel];
    prv   = lv_lane[MAX_DEGREE][sel_m1];
    left  = (fin_ctrl.idx <= fin_ctrl.target) ? cur : '0;
    right = (fin_ctrl.idx != '0) ? prv : '0;
    if (!fin_ctrl.in_sup) begin
      mag_nxt = '0;
      neg_nxt = 1'b0;
    end else if (!fin_ctrl.mode) begin
      mag_nxt = cur;
      neg_nxt = 1'b0;
    end else if (left >= right) begin
      mag_nxt = left - right;
      neg_nxt = 1'b0;
    end else begin
      mag_nxt = right - left;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid7_r <= 1'b0;
    end else begin
      valid7_r <= lv_valid[MAX_DEGREE];
    end
    status7_r <= fin_ctrl.status;
    neg7_r    <= neg_nxt;
    mag7_r    <= mag_nxt;
  end

  // Output stage: round half up to the output format and apply the sign.
  logic [RND_W-1:0] rnd_sum;
  logic [RES_W-1:0] rnd;
  logic [RES_W-1:0] res_nxt;
  logic             out_valid_r;
  logic [RES_W-1:0] out_result_r;
  logic             out_status_r;

  always_comb begin
    rnd_sum = RND_W'(mag7_r) + RND_HALF;
    rnd     = rnd_sum[ROUND_SH +: RES_W];
    res_nxt = neg7_r ? (RES_W'(0) - rnd) : rnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= valid7_r;
    end
    out_result_r <= res_nxt;
    out_status_r <= status7_r;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = $signed(out_result_r);
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

[hdl/cbs_level.sv]
// ============================================================================
// cbs_level - one degree step of the Cox-de Boor recurrence
// Raises the basis values of lanes 0 to LEVEL by one degree when the word's target
// degree reaches this step, and passes them on unchanged otherwise.
// ============================================================================
`default_nettype none

module cbs_level
  import cbs_pkg::*;
#(
  parameter int LEVEL = 1,
  parameter int LANES = MAX_DEGREE_DEF + 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  cbs_ctrl_t in_ctrl,
  input  cbs_lane_t in_lane [LANES],
  output logic      out_valid,
  output cbs_ctrl_t out_ctrl,
  output cbs_lane_t out_lane [LANES]
);

  localparam int HI_W = LANE_W - SPLIT;
  localparam int PH_W = HI_W + FRAC_BITS;
  localparam int PL_W = SPLIT + FRAC_BITS;
  localparam bit ODD  = (LEVEL == 3) || (LEVEL == 5);
  localparam int SH   = (LEVEL == 4) ? 2 : ((LEVEL == 2) ? 1 : 0);
  localparam logic [DEG_W-1:0] LEVEL_C = DEG_W'(LEVEL);
  localparam logic [SUM_W-1:0] HALF    = SUM_W'(LEVEL / 2);

  // Stage 1: products with the fraction and the linear terms.
  cbs_lane_t        a_op   [LANES];
  cbs_lane_t        b_op   [LANES];
  logic [PH_W-1:0]  pah_nxt [LANES];
  logic [PL_W-1:0]  pal_nxt [LANES];
  logic [PH_W-1:0]  pbh_nxt [LANES];
  logic [PL_W-1:0]  pbl_nxt [LANES];
  logic [SUM_W-1:0] lin_nxt [LANES];

  logic             valid1_r;
  cbs_ctrl_t        ctrl1_r;
  cbs_lane_t        lane1_r [LANES];
  logic [PH_W-1:0]  pah_r   [LANES];
  logic [PL_W-1:0]  pal_r   [LANES];
  logic [PH_W-1:0]  pbh_r   [LANES];
  logic [PL_W-1:0]  pbl_r   [LANES];
  logic [SUM_W-1:0] lin_r   [LANES];

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      a_op[r]    = (r < LEVEL) ? in_lane[r] : '0;
      b_op[r]    = (r > 0 && r <= LEVEL) ? in_lane[(r == 0) ? 0 : r - 1] : '0;
      pah_nxt[r] = PH_W'(a_op[r][LANE_W-1:SPLIT]) * PH_W'(in_ctrl.frac);
      pal_nxt[r] = PL_W'(a_op[r][SPLIT-1:0]) * PL_W'(in_ctrl.frac);
      pbh_nxt[r] = PH_W'(b_op[r][LANE_W-1:SPLIT]) * PH_W'(in_ctrl.frac);
      pbl_nxt[r] = PL_W'(b_op[r][SPLIT-1:0]) * PL_W'(in_ctrl.frac);
      lin_nxt[r] = SUM_W'(r) * SUM_W'(a_op[r])
                 + SUM_W'(LEVEL + 1 - r) * SUM_W'(b_op[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
    end else begin
      valid1_r <= in_valid;
    end
    ctrl1_r <= in_ctrl;
    for (int r = 0; r < LANES; r++) begin
      lane1_r[r] <= in_lane[r];
      pah_r[r]   <= pah_nxt[r];
      pal_r[r]   <= pal_nxt[r];
      pbh_r[r]   <= pbh_nxt[r];
      pbl_r[r]   <= pbl_nxt[r];
      lin_r[r]   <= lin_nxt[r];
    end
  end

  // Stage 2: recombine the partial products and add the rounding half.
  logic             act2;
  logic [SUM_W-1:0] ma [LANES];
  logic [SUM_W-1:0] mb [LANES];
  logic [SUM_W-1:0] n2_nxt [LANES];

  assign act2 = (ctrl1_r.target >= LEVEL_C);

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      ma[r] = (SUM_W'(pah_r[r]) << (SPLIT - FRAC_BITS)) + SUM_W'(pal_r[r] >> FRAC_BITS);
      mb[r] = (SUM_W'(pbh_r[r]) << (SPLIT - FRAC_BITS)) + SUM_W'(pbl_r[r] >> FRAC_BITS);
      if (act2 && (r <= LEVEL)) begin
        n2_nxt[r] = lin_r[r] + ma[r] - mb[r] + HALF;
      end else begin
        n2_nxt[r] = SUM_W'(lane1_r[r]);
      end
    end
  end

  if (!ODD) begin : g_even
    // Division by one, two or four is a plain shift.
    logic      valid2_r;
    cbs_ctrl_t ctrl2_r;
    cbs_lane_t lane2_r [LANES];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid2_r <= 1'b0;
      end else begin
        valid2_r <= valid1_r;
      end
      ctrl2_r <= ctrl1_r;
      for (int r = 0; r < LANES; r++) begin
        if (act2 && (r <= LEVEL)) begin
          lane2_r[r] <= LANE_W'(n2_nxt[r] >> SH);
        end else begin
          lane2_r[r] <= lane1_r[r];
        end
      end
    end

    assign out_valid = valid2_r;
    assign out_ctrl  = ctrl2_r;
    assign out_lane  = lane2_r;
  end else begin : g_odd
    // Division by three or five: a shift-and-add reciprocal that never
    // overshoots, then a small correction from the low bits of the remainder.
    localparam logic [4:0] DIV_LO = 5'(LEVEL);

    function automatic logic [3:0] small_quot(input logic [4:0] rem);
      logic [3:0] quot;
      quot = '0;
      for (int k = 1; k <= 10; k++) begin
        if (int'(rem) >= k * LEVEL) begin
          quot = 4'(k);
        end
      end
      return quot;
    endfunction

    logic             valid2_r, valid3_r, valid4_r, valid5_r, valid6_r;
    cbs_ctrl_t        ctrl2_r, ctrl3_r, ctrl4_r, ctrl5_r, ctrl6_r;
    logic [SUM_W-1:0] n2_r [LANES];
    logic [SUM_W-1:0] n3_r [LANES];
    logic [SUM_W-1:0] n4_r [LANES];
    logic [SUM_W-1:0] n5_r [LANES];
    logic [SUM_W-1:0] q3_r [LANES];
    logic [SUM_W-1:0] q4_r [LANES];
    logic [SUM_W-1:0] q5_r [LANES];
    cbs_lane_t        lane6_r [LANES];

    logic [SUM_W-1:0] t0     [LANES];
    logic [SUM_W-1:0] q3_nxt [LANES];
    logic [SUM_W-1:0] q2     [LANES];
    logic [SUM_W-1:0] q4_nxt [LANES];
    logic [SUM_W-1:0] q5_nxt [LANES];
    logic [4:0]       rem    [LANES];
    logic [SUM_W-1:0] q_fix  [LANES];
    cbs_lane_t        lane6_nxt [LANES];
    logic             act6;

    assign act6 = (ctrl5_r.target >= LEVEL_C);

    always_comb begin
      for (int r = 0; r < LANES; r++) begin
        // First approximation of n/LEVEL and its first refinement.
        if (LEVEL == 5) begin
          t0[r] = (n2_r[r] >> 1) + (n2_r[r] >> 2);
        end else begin
          t0[r] = (n2_r[r] >> 2) + (n2_r[r] >> 4);
        end
        q3_nxt[r] = t0[r] + (t0[r] >> 4);
        // Two more refinements.
        q2[r]     = q3_r[r] + (q3_r[r] >> 8);
        q4_nxt[r] = q2[r] + (q2[r] >> 16);
        // Last refinement; the divide by five needs a final quarter.
        if (LEVEL == 5) begin
          q5_nxt[r] = (q4_r[r] + (q4_r[r] >> 32)) >> 2;
        end else begin
          q5_nxt[r] = q4_r[r] + (q4_r[r] >> 32);
        end
        // The remainder is small, so its low bits are all of it.
        rem[r]   = n5_r[r][4:0] - 5'(q5_r[r][4:0] * DIV_LO);
        q_fix[r] = q5_r[r] + SUM_W'(small_quot(rem[r]));
        if (act6 && (r <= LEVEL)) begin
          lane6_nxt[r] = q_fix[r][LANE_W-1:0];
        end else begin
          lane6_nxt[r] = n5_r[r][LANE_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid2_r <= 1'b0;
        valid3_r <= 1'b0;
        valid4_r <= 1'b0;
        valid5_r <= 1'b0;
        valid6_r <= 1'b0;
      end else begin
        valid2_r <= valid1_r;
        valid3_r <= valid2_r;
        valid4_r <= valid3_r;
        valid5_r <= valid4_r;
        valid6_r <= valid5_r;
      end
      ctrl2_r <= ctrl1_r;
      ctrl3_r <= ctrl2_r;
      ctrl4_r <= ctrl3_r;
      ctrl5_r <= ctrl4_r;
      ctrl6_r <= ctrl5_r;
      for (int r = 0; r < LANES; r++) begin
        n2_r[r]    <= n2_nxt[r];
        n3_r[r]    <= n2_r[r];
        q3_r[r]    <= q3_nxt[r];
        n4_r[r]    <= n3_r[r];
        q4_r[r]    <= q4_nxt[r];
        n5_r[r]    <= n4_r[r];
        q5_r[r]    <= q5_nxt[r];
        lane6_r[r] <= lane6_nxt[r];
      end
    end

    assign out_valid = valid6_r;
    assign out_ctrl  = ctrl6_r;
    assign out_lane  = lane6_r;
  end

endmodule

`default_nettype wire

[hdl/cbs_checker.sv]
// ============================================================================
// cbs_checker - port-level checks for the cardinal B-spline evaluator
// Watches the ports for latency, word count, range and status behaviour.
// ============================================================================
`default_nettype none

module cbs_checker
  import cbs_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    in_mode,
  input logic [DEG_W-1:0]        in_degree,
  input logic                    out_valid,
  input logic signed [RES_W-1:0] out_result_value,
  input logic                    out_status
);

  localparam int ODD_STEPS = ((MAX_DEGREE >= 3) ? 1 : 0) + ((MAX_DEGREE >= 5) ? 1 : 0);
  localparam int LATENCY   = 3 + 2 * MAX_DEGREE + 4 * ODD_STEPS;
  localparam int WARM_W    = $clog2(LATENCY + 1);
  localparam logic [WARM_W-1:0] WARM_FULL = WARM_W'(LATENCY);

  // Cycles since reset, so that look-backs stay clear of the reset period.
  logic [WARM_W-1:0] warm_r;
  logic [WARM_W-1:0] warm_nxt;
  logic              warm;

  assign warm     = (warm_r == WARM_FULL);
  assign warm_nxt = warm ? warm_r : warm_r + WARM_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else begin
      warm_r <= warm_nxt;
    end
  end

  // Every accepted word gives exactly one result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_valid == $past(start && !busy, LATENCY)))
    else $error("result strobe does not match an accepted word");

  // A derivative at degree zero is flagged.
  a_status_set: assert property (@(posedge clk) disable iff (!rst_n)
    warm && $past(start && !busy && in_mode && (in_degree == '0), LATENCY) |-> out_status)
    else $error("derivative at degree zero not flagged");

  // A flagged result carries zero.
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> (out_result_value == '0))
    else $error("flagged result is not zero");

  // Values and derivatives never exceed one in magnitude.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_value <= 18'sd65536) && (out_result_value >= -18'sd65536))
    else $error("result outside the range of one");

endmodule

bind cardinal_bspline_evaluator cbs_checker #(
  .MAX_DEGREE (MAX_DEGREE)
) u_cbs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .in_degree        (in_degree),
  .out_valid        (out_valid),
  .out_result_value (out_result_value),
  .out_status       (out_status)
);

`default_nettype wire
